@@ hdl/bir_pkg.sv @@
// shared widths, register map and pipeline tag type for the bilinear resampler
package bir_pkg;

  localparam int PIX_W    = 8;
  localparam int SCOL_W   = 9;
  localparam int DCOL_W   = 11;
  localparam int SDIM_W   = 10;
  localparam int DDIM_W   = 12;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam int MAX_SRC_DIM_DEF = 512;
  localparam int MAX_DST_DIM_DEF = 2048;

  localparam logic [SDIM_W-1:0] SRC_DIM_RST = SDIM_W'(512);
  localparam logic [DDIM_W-1:0] DST_DIM_RST = DDIM_W'(512);

  // register indexes
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic              vld;
    logic              negx;
    logic              negy;
    logic [DCOL_W-1:0] col;
    logic [DCOL_W-1:0] row;
  } bir_tag_t;

endpackage

@@ hdl/bir_ram.sv @@
// generic single write port ram with registered read
module bir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bir_coord.sv @@
// pipelined restoring divider, one quotient bit per stage, for source coordinates
module bir_coord #(
  parameter int NUM_W = 22,
  parameter int DV_W  = 13
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DV_W-1:0]  dv_i,
  output logic [NUM_W-1:0] q_o,
  output logic [DV_W-1:0]  r_o
);

  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [DV_W-1:0]  rem_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [NUM_W-1:0] num_p;
    logic [NUM_W-1:0] quo_p;
    logic [DV_W-1:0]  rem_p;
    logic [DV_W:0]    sh;
    logic [DV_W-1:0]  rem_d;
    logic [NUM_W-1:0] quo_d;

    if (i == 0) begin : g_first
      assign num_p = num_i;
      assign quo_p = '0;
      assign rem_p = '0;
    end else begin : g_next
      assign num_p = num_q[i-1];
      assign quo_p = quo_q[i-1];
      assign rem_p = rem_q[i-1];
    end

    always_comb begin
      sh    = {rem_p, num_p[NUM_W-1-i]};
      quo_d = quo_p;
      if (sh >= {1'b0, dv_i}) begin
        rem_d              = DV_W'(sh - {1'b0, dv_i});
        quo_d[NUM_W-1-i]   = 1'b1;
      end else begin
        rem_d = sh[DV_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[i] <= num_p;
      quo_q[i] <= quo_d;
      rem_q[i] <= rem_d;
    end
  end

  assign q_o = quo_q[NUM_W-1];
  assign r_o = rem_q[NUM_W-1];

endmodule

@@ hdl/bir_store.sv @@
// frame store split into four row/column parity banks, all four neighbours per cycle
module bir_store import bir_pkg::*; #(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int SC_W        = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SC_W-1:0]  wcol_i,
  input  logic [SC_W-1:0]  wrow_i,
  input  logic [PIX_W-1:0] wdata_i,
  input  logic [SC_W-1:0]  rcol0_i,
  input  logic [SC_W-1:0]  rcol1_i,
  input  logic [SC_W-1:0]  rrow0_i,
  input  logic [SC_W-1:0]  rrow1_i,
  output logic [PIX_W-1:0] pix00_o,
  output logic [PIX_W-1:0] pix10_o,
  output logic [PIX_W-1:0] pix01_o,
  output logic [PIX_W-1:0] pix11_o
);

  localparam int HALF    = (MAX_SRC_DIM + 1) / 2;
  localparam int BANK_D  = HALF * HALF;
  localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  logic [PIX_W-1:0]   rdata [4];
  logic [BANK_AW-1:0] waddr;
  logic               px0_q, px1_q, py0_q, py1_q;

  assign waddr = BANK_AW'((32'(wrow_i) >> 1) * HALF + (32'(wcol_i) >> 1));

  for (genvar pr = 0; pr < 2; pr++) begin : g_row
    for (genvar pc = 0; pc < 2; pc++) begin : g_col
      logic [SC_W-1:0]    rcol;
      logic [SC_W-1:0]    rrow;
      logic [BANK_AW-1:0] raddr;
      logic               bank_we;

      // each bank serves whichever neighbour coordinate has its parity
      assign rcol    = (rcol0_i[0] == 1'(pc)) ? rcol0_i : rcol1_i;
      assign rrow    = (rrow0_i[0] == 1'(pr)) ? rrow0_i : rrow1_i;
      assign raddr   = BANK_AW'((32'(rrow) >> 1) * HALF + (32'(rcol) >> 1));
      assign bank_we = we_i && (wrow_i[0] == 1'(pr)) && (wcol_i[0] == 1'(pc));

      bir_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_D)
      ) u_bank (
        .clk_i   (clk_i),
        .we_i    (bank_we),
        .waddr_i (waddr),
        .wdata_i (wdata_i),
        .raddr_i (raddr),
        .rdata_o (rdata[pr*2+pc])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    px0_q <= rcol0_i[0];
    px1_q <= rcol1_i[0];
    py0_q <= rrow0_i[0];
    py1_q <= rrow1_i[0];
  end

  assign pix00_o = rdata[{py0_q, px0_q}];
  assign pix10_o = rdata[{py0_q, px1_q}];
  assign pix01_o = rdata[{py1_q, px0_q}];
  assign pix11_o = rdata[{py1_q, px1_q}];

endmodule

@@ hdl/bir_norm.sv @@
// pipelined divide of the weighted sum by the area, one result bit per stage
module bir_norm import bir_pkg::*; #(
  parameter int SUM_W = 36,
  parameter int DEN_W = 26
) (
  input  logic             clk_i,
  input  logic [SUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [PIX_W-1:0] q_o
);

  logic [SUM_W-1:0] rem_q [PIX_W];
  logic [PIX_W-1:0] quo_q [PIX_W];

  for (genvar i = 0; i < PIX_W; i++) begin : g_stage
    logic [SUM_W-1:0] rem_p;
    logic [PIX_W-1:0] quo_p;
    logic [SUM_W-1:0] dsh;
    logic [SUM_W-1:0] rem_d;
    logic [PIX_W-1:0] quo_d;

    if (i == 0) begin : g_first
      assign rem_p = num_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[i-1];
      assign quo_p = quo_q[i-1];
    end

    assign dsh = SUM_W'(den_i) << (PIX_W - 1 - i);

    always_comb begin
      quo_d = quo_p;
      rem_d = rem_p;
      if (rem_p >= dsh) begin
        rem_d              = rem_p - dsh;
        quo_d[PIX_W-1-i]   = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      quo_q[i] <= quo_d;
    end
  end

  assign q_o = quo_q[PIX_W-1];

endmodule

@@ hdl/bilinear_image_resampler.sv @@
// Grayscale bilinear resampler with frame store and APB register port
//
// Usage: configure source and destination sizes over APB while idle, then
// issue commands with start_i. A command with req_type_i low writes src_pixel_i
// into the frame store at (src_col_i, src_row_i) and gives no result. A command
// with req_type_i high asks for destination pixel (dst_col_i, dst_row_i); the
// answer appears on out_pixel_o, out_col_o and out_row_o with out_valid_o high
// for one cycle.
// busy_o never rises: one command is taken every cycle.
// NUM_W is the coordinate divider depth (one stage per quotient bit). The
// two pipelined dividers and the four-bank store read set the stage count.
// Loads travel down a write line and hit the store at the same pipeline point
// where requests read it, so every request sees exactly the loads before it.
// Reset clears the pipeline valid bits and sets all four sizes to 512; the
// frame store keeps no reset contents. The receiver cannot stall, so results
// flow out at the input rate.
module bilinear_image_resampler import bir_pkg::*; #(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = MAX_DST_DIM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              req_type_i,
  input  logic [SCOL_W-1:0] src_col_i,
  input  logic [SCOL_W-1:0] src_row_i,
  input  logic [PIX_W-1:0]  src_pixel_i,
  input  logic [DCOL_W-1:0] dst_col_i,
  input  logic [DCOL_W-1:0] dst_row_i,
  output logic              out_valid_o,
  output logic [PIX_W-1:0]  out_pixel_o,
  output logic [DCOL_W-1:0] out_col_o,
  output logic [DCOL_W-1:0] out_row_o,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o
);

  localparam int SD_W       = $clog2(MAX_SRC_DIM + 1);
  localparam int DD_W       = $clog2(MAX_DST_DIM + 1);
  localparam int SC_W       = $clog2(MAX_SRC_DIM);
  localparam int PW         = DCOL_W + 1 + SD_W;
  localparam int DV_W       = DD_W + 1;
  localparam int NUM_W      = (PW > DV_W) ? PW : DV_W;
  localparam int WW         = 2 * DV_W;
  localparam int DEN_W      = 2 * DD_W + 2;
  localparam int TERM_W     = WW + PIX_W;
  localparam int SUM_W      = WW + PIX_W + 2;
  localparam int MID_STAGES = 4;
  localparam int TL         = NUM_W + MID_STAGES + PIX_W;
  localparam int WR_DLY     = NUM_W + 2;

  // configuration
  logic [SDIM_W-1:0] src_w_q, src_h_q;
  logic [DDIM_W-1:0] dst_w_q, dst_h_q;
  logic              cfg_wr;
  logic [SD_W-1:0]   sw_lim, sh_lim;
  logic [DD_W-1:0]   dw_lim, dh_lim;
  logic [DEN_W-1:0]  den_q;

  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign busy_o   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_DIM_RST;
      src_h_q <= SRC_DIM_RST;
      dst_w_q <= DST_DIM_RST;
      dst_h_q <= DST_DIM_RST;
    end else if (cfg_wr) begin
      case (paddr_i[3:2])
        REG_SRC_WIDTH:  src_w_q <= pwdata_i[SDIM_W-1:0];
        REG_SRC_HEIGHT: src_h_q <= pwdata_i[SDIM_W-1:0];
        REG_DST_WIDTH:  dst_w_q <= pwdata_i[DDIM_W-1:0];
        REG_DST_HEIGHT: dst_h_q <= pwdata_i[DDIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      REG_SRC_WIDTH:  prdata_o = APB_DW'(src_w_q);
      REG_SRC_HEIGHT: prdata_o = APB_DW'(src_h_q);
      REG_DST_WIDTH:  prdata_o = APB_DW'(dst_w_q);
      REG_DST_HEIGHT: prdata_o = APB_DW'(dst_h_q);
      default:        prdata_o = '0;
    endcase
  end

  // zero reads as one, oversize as the maximum
  assign sw_lim = (src_w_q == '0) ? SD_W'(1) :
                  (32'(src_w_q) > 32'(MAX_SRC_DIM)) ? SD_W'(MAX_SRC_DIM) : SD_W'(src_w_q);
  assign sh_lim = (src_h_q == '0) ? SD_W'(1) :
                  (32'(src_h_q) > 32'(MAX_SRC_DIM)) ? SD_W'(MAX_SRC_DIM) : SD_W'(src_h_q);
  assign dw_lim = (dst_w_q == '0) ? DD_W'(1) :
                  (32'(dst_w_q) > 32'(MAX_DST_DIM)) ? DD_W'(MAX_DST_DIM) : DD_W'(dst_w_q);
  assign dh_lim = (dst_h_q == '0) ? DD_W'(1) :
                  (32'(dst_h_q) > 32'(MAX_DST_DIM)) ? DD_W'(MAX_DST_DIM) : DD_W'(dst_h_q);

  always_ff @(posedge clk_i) begin
    den_q <= DEN_W'(DEN_W'(dw_lim) * DEN_W'(dh_lim)) << 2;
  end

  // stage 1: command registers, store write request
  logic              v1_q;
  logic              req1_q;
  logic [SCOL_W-1:0] scol1_q, srow1_q;
  logic [PIX_W-1:0]  spix1_q;
  logic [DCOL_W-1:0] dcol1_q, drow1_q;
  logic              st_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    req1_q  <= req_type_i;
    scol1_q <= src_col_i;
    srow1_q <= src_row_i;
    spix1_q <= src_pixel_i;
    dcol1_q <= dst_col_i;
    drow1_q <= dst_row_i;
  end

  assign st_we = v1_q && !req1_q && (32'(scol1_q) < 32'(MAX_SRC_DIM))
                 && (32'(srow1_q) < 32'(MAX_SRC_DIM));

  // load write line, the last entry lines up with the stage that reads the store
  logic              wr_v_q   [WR_DLY];
  logic [SC_W-1:0]   wr_col_q [WR_DLY];
  logic [SC_W-1:0]   wr_row_q [WR_DLY];
  logic [PIX_W-1:0]  wr_pix_q [WR_DLY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WR_DLY; k++) begin
        wr_v_q[k] <= 1'b0;
      end
    end else begin
      wr_v_q[0] <= st_we;
      for (int k = 1; k < WR_DLY; k++) begin
        wr_v_q[k] <= wr_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_col_q[0] <= SC_W'(scol1_q);
    wr_row_q[0] <= SC_W'(srow1_q);
    wr_pix_q[0] <= spix1_q;
    for (int k = 1; k < WR_DLY; k++) begin
      wr_col_q[k] <= wr_col_q[k-1];
      wr_row_q[k] <= wr_row_q[k-1];
      wr_pix_q[k] <= wr_pix_q[k-1];
    end
  end

  // stage 2: (2x+1)*W
  logic              v2_q;
  logic [DCOL_W-1:0] dcol2_q, drow2_q;
  logic [PW-1:0]     prod_x_q, prod_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q && req1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dcol2_q  <= dcol1_q;
    drow2_q  <= drow1_q;
    prod_x_q <= PW'({dcol1_q, 1'b1}) * PW'(sw_lim);
    prod_y_q <= PW'({drow1_q, 1'b1}) * PW'(sh_lim);
  end

  // stage 3: subtract w; a negative offset wraps up by 2w and marks x0 = -1
  bir_tag_t         tag3_q;
  logic [NUM_W-1:0] num_x_q, num_y_q;
  logic [NUM_W-1:0] pxe, pye, dwe, dhe;

  assign pxe = NUM_W'(prod_x_q);
  assign pye = NUM_W'(prod_y_q);
  assign dwe = NUM_W'(dw_lim);
  assign dhe = NUM_W'(dh_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag3_q <= '0;
    end else begin
      tag3_q.vld  <= v2_q;
      tag3_q.negx <= pxe < dwe;
      tag3_q.negy <= pye < dhe;
      tag3_q.col  <= dcol2_q;
      tag3_q.row  <= drow2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_x_q <= (pxe >= dwe) ? (pxe - dwe) : (pxe + dwe);
    num_y_q <= (pye >= dhe) ? (pye - dhe) : (pye + dhe);
  end

  // coordinate dividers
  logic [NUM_W-1:0] qx, qy;
  logic [DV_W-1:0]  rx, ry;
  logic [DV_W-1:0]  dvx, dvy;

  assign dvx = {dw_lim, 1'b0};
  assign dvy = {dh_lim, 1'b0};

  bir_coord #(.NUM_W(NUM_W), .DV_W(DV_W)) u_coord_x (
    .clk_i (clk_i), .num_i (num_x_q), .dv_i (dvx), .q_o (qx), .r_o (rx)
  );

  bir_coord #(.NUM_W(NUM_W), .DV_W(DV_W)) u_coord_y (
    .clk_i (clk_i), .num_i (num_y_q), .dv_i (dvy), .q_o (qy), .r_o (ry)
  );

  // tag line that runs beside the arithmetic
  bir_tag_t tag_q [TL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TL; k++) begin
        tag_q[k] <= '0;
      end
    end else begin
      tag_q[0] <= tag3_q;
      for (int k = 1; k < TL; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // stage 4: edge clamp and fractional weights
  bir_tag_t         tag_c;
  logic [NUM_W:0]   qxe, qye, qx1, qy1, swe, she;
  logic [SC_W-1:0]  cx0_q, cx1_q, cy0_q, cy1_q;
  logic [SC_W-1:0]  sw_top, sh_top;
  logic [DV_W-1:0]  rx_q, ax_q, ry_q, ay_q;

  assign tag_c  = tag_q[NUM_W-1];
  assign qxe    = {1'b0, qx};
  assign qye    = {1'b0, qy};
  assign qx1    = qxe + 1'b1;
  assign qy1    = qye + 1'b1;
  assign swe    = (NUM_W+1)'(sw_lim);
  assign she    = (NUM_W+1)'(sh_lim);
  assign sw_top = SC_W'(sw_lim - 1'b1);
  assign sh_top = SC_W'(sh_lim - 1'b1);

  always_ff @(posedge clk_i) begin
    if (tag_c.negx) begin
      cx0_q <= '0;
      cx1_q <= '0;
    end else begin
      cx0_q <= (qxe >= swe) ? sw_top : SC_W'(qxe);
      cx1_q <= (qx1 >= swe) ? sw_top : SC_W'(qx1);
    end
    if (tag_c.negy) begin
      cy0_q <= '0;
      cy1_q <= '0;
    end else begin
      cy0_q <= (qye >= she) ? sh_top : SC_W'(qye);
      cy1_q <= (qy1 >= she) ? sh_top : SC_W'(qy1);
    end
    rx_q <= rx;
    ry_q <= ry;
    ax_q <= dvx - rx;
    ay_q <= dvy - ry;
  end

  // stage 5: store read, weight products
  logic [PIX_W-1:0] pix00, pix10, pix01, pix11;
  logic [WW-1:0]    w00_q, w10_q, w01_q, w11_q;

  bir_store #(.MAX_SRC_DIM(MAX_SRC_DIM), .SC_W(SC_W)) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_v_q[WR_DLY-1]),
    .wcol_i  (wr_col_q[WR_DLY-1]),
    .wrow_i  (wr_row_q[WR_DLY-1]),
    .wdata_i (wr_pix_q[WR_DLY-1]),
    .rcol0_i (cx0_q),
    .rcol1_i (cx1_q),
    .rrow0_i (cy0_q),
    .rrow1_i (cy1_q),
    .pix00_o (pix00),
    .pix10_o (pix10),
    .pix01_o (pix01),
    .pix11_o (pix11)
  );

  always_ff @(posedge clk_i) begin
    w00_q <= WW'(ax_q) * WW'(ay_q);
    w10_q <= WW'(rx_q) * WW'(ay_q);
    w01_q <= WW'(ax_q) * WW'(ry_q);
    w11_q <= WW'(rx_q) * WW'(ry_q);
  end

  // stage 6: weighted neighbours
  logic [TERM_W-1:0] t00_q, t10_q, t01_q, t11_q;

  always_ff @(posedge clk_i) begin
    t00_q <= TERM_W'(w00_q) * TERM_W'(pix00);
    t10_q <= TERM_W'(w10_q) * TERM_W'(pix10);
    t01_q <= TERM_W'(w01_q) * TERM_W'(pix01);
    t11_q <= TERM_W'(w11_q) * TERM_W'(pix11);
  end

  // stage 7: sum plus half the area for round half up
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    sum_q <= SUM_W'(t00_q) + SUM_W'(t10_q) + SUM_W'(t01_q) + SUM_W'(t11_q)
             + SUM_W'(den_q >> 1);
  end

  bir_norm #(.SUM_W(SUM_W), .DEN_W(DEN_W)) u_norm (
    .clk_i (clk_i),
    .num_i (sum_q),
    .den_i (den_q),
    .q_o   (out_pixel_o)
  );

  assign out_valid_o = tag_q[TL-1].vld;
  assign out_col_o   = tag_q[TL-1].col;
  assign out_row_o   = tag_q[TL-1].row;

endmodule

@@ hdl/bir_checker.sv @@
// port level checks for the bilinear resampler and their bind
module bir_assert import bir_pkg::*; #(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = MAX_DST_DIM_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              req_type_i,
  input logic [DCOL_W-1:0] dst_col_i,
  input logic [DCOL_W-1:0] dst_row_i,
  input logic              out_valid_o,
  input logic [DCOL_W-1:0] out_col_o,
  input logic [DCOL_W-1:0] out_row_o,
  input logic              psel_i,
  input logic              penable_i,
  input logic              pwrite_i,
  input logic [APB_AW-1:0] paddr_i,
  input logic [APB_DW-1:0] prdata_o
);

  localparam int SD_W  = $clog2(MAX_SRC_DIM + 1);
  localparam int DD_W  = $clog2(MAX_DST_DIM + 1);
  localparam int PW    = DCOL_W + 1 + SD_W;
  localparam int DV_W  = DD_W + 1;
  localparam int NUM_W = (PW > DV_W) ? PW : DV_W;
  localparam int LAT   = NUM_W + 15;

  // every result comes from a pixel request a fixed time earlier
  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start_i && req_type_i, LAT))
    else $error("result without a matching request");

  a_result_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_col_o == $past(dst_col_i, LAT)) && (out_row_o == $past(dst_row_i, LAT)))
    else $error("result coordinates do not match the request");

  // registers only change through a write transfer
  a_regs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(psel_i && penable_i && pwrite_i) && $stable(paddr_i)) |-> $stable(prdata_o))
    else $error("register value changed without a write");

endmodule

bind bilinear_image_resampler bir_assert #(
  .MAX_SRC_DIM (MAX_SRC_DIM),
  .MAX_DST_DIM (MAX_DST_DIM)
) u_bir_assert (.*);

@@ verif/bir_checker.sv @@
// bus monitor, bilinear pixel predictor and result scoreboard for the resampler
`timescale 1ns / 100ps
module bir_checker import bir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic              req_type_i,
  input  logic [SCOL_W-1:0] src_col_i,
  input  logic [SCOL_W-1:0] src_row_i,
  input  logic [PIX_W-1:0]  src_pixel_i,
  input  logic [DCOL_W-1:0] dst_col_i,
  input  logic [DCOL_W-1:0] dst_row_i,
  input  logic              out_valid_i,
  input  logic [PIX_W-1:0]  out_pixel_i,
  input  logic [DCOL_W-1:0] out_col_i,
  input  logic [DCOL_W-1:0] out_row_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  input  logic              pready_i,
  output int                pending_o,
  output int                errors_o
);

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [DCOL_W-1:0] col;
    logic [DCOL_W-1:0] row;
  } dst_pixel_t;

  localparam int SRC_MAX = MAX_SRC_DIM_DEF;
  localparam int DST_MAX = MAX_DST_DIM_DEF;

  logic [PIX_W-1:0]  frame_mem [SRC_MAX*SRC_MAX];
  logic [SDIM_W-1:0] sw_reg, sh_reg;
  logic [DDIM_W-1:0] dw_reg, dh_reg;
  dst_pixel_t        expected_q [$];

  function automatic longint eff_dim(longint v, longint maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    return q;
  endfunction

  function automatic longint fetch(longint c, longint r, longint sw, longint sh);
    longint cc, rr;
    cc = (c < 0) ? 0 : ((c >= sw) ? sw - 1 : c);
    rr = (r < 0) ? 0 : ((r >= sh) ? sh - 1 : r);
    return longint'(frame_mem[rr * SRC_MAX + cc]);
  endfunction

  function automatic logic [PIX_W-1:0] interp_pixel(longint dc, longint dr);
    longint sw, sh, dw, dh, nx, ny, x0, y0, rx, ry, ax, ay, acc, den, val;
    sw = eff_dim(sw_reg, SRC_MAX);
    sh = eff_dim(sh_reg, SRC_MAX);
    dw = eff_dim(dw_reg, DST_MAX);
    dh = eff_dim(dh_reg, DST_MAX);
    nx = (2 * dc + 1) * sw - dw;
    ny = (2 * dr + 1) * sh - dh;
    x0 = floor_quot(nx, 2 * dw);
    y0 = floor_quot(ny, 2 * dh);
    rx = nx - x0 * 2 * dw;
    ry = ny - y0 * 2 * dh;
    ax = 2 * dw - rx;
    ay = 2 * dh - ry;
    acc = ax * ay * fetch(x0, y0, sw, sh) + rx * ay * fetch(x0 + 1, y0, sw, sh)
        + ax * ry * fetch(x0, y0 + 1, sw, sh) + rx * ry * fetch(x0 + 1, y0 + 1, sw, sh);
    den = 4 * dw * dh;
    val = (acc + den / 2) / den;
    if (val > 255) val = 255;
    return PIX_W'(val);
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    dst_pixel_t exp_pix;
    if (!rst_ni) begin
      sw_reg   <= SRC_DIM_RST;
      sh_reg   <= SRC_DIM_RST;
      dw_reg   <= DST_DIM_RST;
      dh_reg   <= DST_DIM_RST;
      errors_o <= 0;
      expected_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_SRC_WIDTH:  sw_reg <= pwdata_i[SDIM_W-1:0];
          REG_SRC_HEIGHT: sh_reg <= pwdata_i[SDIM_W-1:0];
          REG_DST_WIDTH:  dw_reg <= pwdata_i[DDIM_W-1:0];
          REG_DST_HEIGHT: dh_reg <= pwdata_i[DDIM_W-1:0];
          default: ;
        endcase
      end
      // results leave before this edge's request joins the queue
      if (out_valid_i) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected result: pixel %0d col %0d row %0d",
                     out_pixel_i, out_col_i, out_row_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_pix = expected_q.pop_front();
          if (exp_pix.pixel !== out_pixel_i || exp_pix.col !== out_col_i ||
              exp_pix.row !== out_row_i) begin
            if (errors_o < 10)
              $display("mismatch: expected pixel %0d col %0d row %0d, got %0d %0d %0d",
                       exp_pix.pixel, exp_pix.col, exp_pix.row,
                       out_pixel_i, out_col_i, out_row_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (!req_type_i) begin
          frame_mem[int'(src_row_i) * SRC_MAX + int'(src_col_i)] = src_pixel_i;
        end else begin
          exp_pix.pixel = interp_pixel(dst_col_i, dst_row_i);
          exp_pix.col   = dst_col_i;
          exp_pix.row   = dst_row_i;
          expected_q.push_back(exp_pix);
        end
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
// stimulus, clocking and verdict for the bilinear resampler testbench
`timescale 1ns / 100ps
module tb_top;
  import bir_pkg::*;

  logic              clk_i, rst_ni;
  logic              start_i, busy_o, req_type_i;
  logic [SCOL_W-1:0] src_col_i, src_row_i;
  logic [PIX_W-1:0]  src_pixel_i;
  logic [DCOL_W-1:0] dst_col_i, dst_row_i;
  logic              out_valid_o;
  logic [PIX_W-1:0]  out_pixel_o;
  logic [DCOL_W-1:0] out_col_o, out_row_o;
  logic              psel_i, penable_i, pwrite_i, pready_o;
  logic [APB_AW-1:0] paddr_i;
  logic [APB_DW-1:0] pwdata_i, prdata_o;
  int                pending, errors;
  int                sent;
  bit                no_idle;
  int                src_w, src_h;

  bilinear_image_resampler dut (.*);

  bir_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_type_i, .src_col_i, .src_row_i,
    .src_pixel_i, .dst_col_i, .dst_row_i, .out_valid_i(out_valid_o),
    .out_pixel_i(out_pixel_o), .out_col_i(out_col_o), .out_row_i(out_row_o),
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .pready_i(pready_o),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic issue(bit kind, int scol, int srow, int spix, int dcol, int drow);
    int gap;
    req_type_i  <= kind;
    src_col_i   <= SCOL_W'(scol);
    src_row_i   <= SCOL_W'(srow);
    src_pixel_i <= PIX_W'(spix);
    dst_col_i   <= DCOL_W'(dcol);
    dst_row_i   <= DCOL_W'(drow);
    start_i     <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
    gap = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:  gap = $urandom_range(1, 3);
        6:                 gap = $urandom_range(10, 40);
        default:           gap = 0;
      endcase
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic reg_write(logic [1:0] idx, int value);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {idx, 2'b00};
    pwdata_i  <= APB_DW'(value);
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // drain, let loads settle, then set all four sizes
  task automatic set_sizes(int sw, int sh, int dw, int dh);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    src_w = (sw % 1024 == 0) ? 1 : ((sw % 1024 > 512) ? 512 : sw % 1024);
    src_h = (sh % 1024 == 0) ? 1 : ((sh % 1024 > 512) ? 512 : sh % 1024);
  endtask

  // fills the active source area so every neighbour read is defined
  task automatic fill_source(int mode);
    int pix;
    for (int r = 0; r < src_h; r++) begin
      for (int c = 0; c < src_w; c++) begin
        pix = (mode == 0) ? (((r + c) % 2 == 0) ? 0 : 255) : $urandom_range(0, 255);
        issue(1'b0, c, r, pix, 0, 0);
      end
    end
  endtask

  initial begin
    int dw, dh, sw, sh;
    start_i = 1'b0; req_type_i = 1'b0; src_col_i = '0; src_row_i = '0;
    src_pixel_i = '0; dst_col_i = '0; dst_row_i = '0;
    psel_i = 1'b0; penable_i = 1'b0; pwrite_i = 1'b0; paddr_i = '0; pwdata_i = '0;
    rst_ni = 1'b0;
    sent = 0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: checkerboard of extreme values, corner and far-out requests
    set_sizes(4, 3, 9, 7);
    fill_source(0);
    issue(1'b1, 0, 0, 0, 0, 0);
    issue(1'b1, 0, 0, 0, 8, 6);
    issue(1'b1, 0, 0, 0, 2047, 2047);
    issue(1'b1, 0, 0, 0, 2047, 0);
    issue(1'b1, 0, 0, 0, 4, 3);
    issue(1'b1, 511, 511, 255, 1, 1);
    issue(1'b1, 0, 0, 0, 1, 1);

    // oversized source width, widest destination, zero dimensions
    set_sizes(1023, 1, 4095, 0);
    fill_source(1);
    for (int i = 0; i < 20; i++)
      issue(1'b1, 0, 0, 0, $urandom_range(0, 2047), $urandom_range(0, 2047));
    set_sizes(0, 512, 0, 2048);
    fill_source(1);
    for (int i = 0; i < 20; i++)
      issue(1'b1, 0, 0, 0, $urandom_range(0, 2047), $urandom_range(0, 2047));

    // random phases, each with a one-in-five chance of no idling
    while (sent < 1300) begin
      no_idle = ($urandom_range(0, 4) == 0);
      sw = $urandom_range(1, 16);
      sh = $urandom_range(1, 16);
      dw = $urandom_range(1, 64);
      dh = $urandom_range(1, 64);
      case ($urandom_range(0, 5))
        0: begin sw = 0; dw = 0; end
        1: begin dw = 2048; dh = $urandom_range(1, 4095); end
        2: begin sh = 1; sw = 512; end
        default: ;
      endcase
      set_sizes(sw, sh, dw, dh);
      fill_source(1);
      for (int i = 0; i < 150; i++) begin
        case ($urandom_range(0, 9))
          0: issue(1'b0, $urandom_range(0, 511), $urandom_range(0, 511),
                   $urandom_range(0, 255), $urandom_range(0, 2047), $urandom_range(0, 2047));
          1: issue(1'b0, $urandom_range(0, src_w - 1), $urandom_range(0, src_h - 1),
                   $urandom_range(0, 255), 0, 0);
          2: issue(1'b1, $urandom_range(0, 511), $urandom_range(0, 511),
                   $urandom_range(0, 255), $urandom_range(0, 2047), $urandom_range(0, 2047));
          default: issue(1'b1, 0, 0, 0, $urandom_range(0, (dw == 0) ? 0 : dw - 1),
                         $urandom_range(0, (dh == 0) ? 0 : dh - 1));
        endcase
      end
    end
    no_idle = 1'b0;

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bir_pkg.sv
hdl/bir_ram.sv
hdl/bir_coord.sv
hdl/bir_store.sv
hdl/bir_norm.sv
hdl/bilinear_image_resampler.sv
hdl/bir_checker.sv
verif/bir_checker.sv
verif/tb_top.sv
